FILE: sv/apmt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the prefix match table.
// No dependencies; used by the front, back and top level.
package apmt_pkg;

    localparam int unsigned KEY_W   = 128;
    localparam int unsigned V4_BITS = 32;
    localparam int unsigned V6_BITS = 128;
    localparam int unsigned MAX_OUT = 32;
    localparam int unsigned CNT_W   = 6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADLEN = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // One classified transaction, as it waits in the queue
    typedef struct packed {
        logic             cmd;
        logic             fam;
        logic             bad_len;
        logic [KEY_W-1:0] key;
        logic [7:0]       plen;
        logic [31:0]      asn;
    } item_t;

    // Queue head handed to the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

FILE: sv/apmt_front.sv
`timescale 1ns / 1ps
// Front end: accepts transactions, normalizes the key, checks the length
// and holds them in a two-entry queue. Depends on apmt_pkg.
module apmt_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 cmd,
    input  logic                 is_ipv6,
    input  logic [63:0]          addr_hi,
    input  logic [63:0]          addr_lo,
    input  logic [7:0]           prefix_len,
    input  logic [31:0]          asn_in,
    input  logic                 pop,
    output logic                 busy,
    output apmt_pkg::head_t      head
);

    apmt_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    apmt_pkg::item_t new_item;
    logic            push;
    logic            do_pop;

    // Classify the incoming transaction
    always_comb
    begin
        new_item.cmd  = cmd;
        new_item.fam  = is_ipv6;
        new_item.key  = is_ipv6 ? {addr_hi, addr_lo} : {96'b0, addr_lo[31:0]};
        new_item.plen = prefix_len;
        new_item.asn  = asn_in;
        new_item.bad_len = (prefix_len == 8'd0) ||
            (prefix_len > (is_ipv6 ? 8'(apmt_pkg::V6_BITS) : 8'(apmt_pkg::V4_BITS)));
    end

    assign busy   = (count_reg == 2'd2);
    assign push   = start && !busy;
    assign do_pop = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

FILE: sv/apmt_back.sv
`timescale 1ns / 1ps
// Back end: entry table, shared parallel comparator, insert and
// length-by-length lookup scan, result register. Depends on apmt_pkg.
module apmt_back
#(
    parameter int unsigned TABLE_DEPTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  apmt_pkg::head_t      head,
    output logic                 pop,
    output logic                 done,
    output logic [1:0]           status,
    output logic                 hit,
    output logic [7:0]           match_len,
    output logic [31:0]          asn_out,
    output logic                 last
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned KW    = apmt_pkg::KEY_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Entry table
    logic              vld_reg  [TABLE_DEPTH];
    logic              efam_reg [TABLE_DEPTH];
    logic [KW-1:0]     ekey_reg [TABLE_DEPTH];
    logic [7:0]        elen_reg [TABLE_DEPTH];
    logic [31:0]       easn_reg [TABLE_DEPTH];

    // Scan context
    logic              fam_reg, fam_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [KW-1:0]     mask_reg, mask_next;
    logic [7:0]        slen_reg, slen_next;
    logic [apmt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic              pend_v_reg, pend_v_next;
    logic [7:0]        pend_len_reg, pend_len_next;
    logic [31:0]       pend_asn_reg, pend_asn_next;

    // Result register
    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic              hit_reg, hit_next;
    logic [7:0]        mlen_reg, mlen_next;
    logic [31:0]       asn_reg, asn_next;
    logic              last_reg, last_next;

    // Compare and write controls
    logic              cmp_fam;
    logic [KW-1:0]     cmp_key;
    logic [7:0]        cmp_len;
    logic              any_hit, any_free;
    logic [IDX_W-1:0]  hit_idx, free_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              scan_end;

    // Select the comparator operands
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            cmp_fam = head.item.fam;
            cmp_key = head.item.key;
            cmp_len = head.item.plen;
        end
        else
        begin
            cmp_fam = fam_reg;
            cmp_key = key_reg & mask_reg;
            cmp_len = slen_reg;
        end
    end

    // Compare all entries, pick the lowest hit and the lowest free slot
    always_comb
    begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (vld_reg[i] && efam_reg[i] == cmp_fam && elen_reg[i] == cmp_len &&
                ekey_reg[i] == cmp_key)
            begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!vld_reg[i])
            begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign scan_end = (slen_reg == 8'd1) ||
        (any_hit && (cnt_reg == apmt_pkg::CNT_W'(apmt_pkg::MAX_OUT - 1)));

    // Sequence inserts and lookups
    always_comb
    begin
        state_next    = state_reg;
        fam_next      = fam_reg;
        key_next      = key_reg;
        mask_next     = mask_reg;
        slen_next     = slen_reg;
        cnt_next      = cnt_reg;
        pend_v_next   = pend_v_reg;
        pend_len_next = pend_len_reg;
        pend_asn_next = pend_asn_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        hit_next      = hit_reg;
        mlen_next     = mlen_reg;
        asn_next      = asn_reg;
        last_next     = last_reg;
        pop           = 1'b0;
        wr_en         = 1'b0;
        wr_idx        = hit_idx;
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.cmd == apmt_pkg::CMD_INSERT)
                    begin
                        done_next = 1'b1;
                        hit_next  = 1'b0;
                        mlen_next = 8'd0;
                        asn_next  = 32'd0;
                        last_next = 1'b1;
                        if (head.item.bad_len)
                        begin
                            status_next = apmt_pkg::ST_BADLEN;
                        end
                        else if (any_hit || any_free)
                        begin
                            status_next = apmt_pkg::ST_OK;
                            wr_en       = 1'b1;
                            wr_idx      = any_hit ? hit_idx : free_idx;
                        end
                        else
                        begin
                            status_next = apmt_pkg::ST_FULL;
                        end
                    end
                    else
                    begin
                        fam_next    = head.item.fam;
                        key_next    = head.item.key;
                        mask_next   = head.item.fam ? {KW{1'b1}} : {96'b0, 32'hFFFF_FFFF};
                        slen_next   = head.item.fam ? 8'(apmt_pkg::V6_BITS)
                                                    : 8'(apmt_pkg::V4_BITS);
                        cnt_next    = '0;
                        pend_v_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Hold one match back so the final one can carry last
                if (any_hit)
                begin
                    if (pend_v_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = apmt_pkg::ST_OK;
                        hit_next    = 1'b1;
                        mlen_next   = pend_len_reg;
                        asn_next    = pend_asn_reg;
                        last_next   = 1'b0;
                    end
                    pend_v_next   = 1'b1;
                    pend_len_next = slen_reg;
                    pend_asn_next = easn_reg[hit_idx];
                    cnt_next      = cnt_reg + 1'b1;
                end
                mask_next = (mask_reg << 1) &
                    (fam_reg ? {KW{1'b1}} : {96'b0, 32'hFFFF_FFFF});
                slen_next = slen_reg - 8'd1;
                if (scan_end)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                done_next   = 1'b1;
                status_next = apmt_pkg::ST_OK;
                hit_next    = pend_v_reg;
                mlen_next   = pend_v_reg ? pend_len_reg : 8'd0;
                asn_next    = pend_v_reg ? pend_asn_reg : 32'd0;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
            cnt_reg    <= '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            pend_v_reg <= pend_v_next;
            cnt_reg    <= cnt_next;
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // Hold payload and table contents
    always_ff @(posedge clk)
    begin
        fam_reg      <= fam_next;
        key_reg      <= key_next;
        mask_reg     <= mask_next;
        slen_reg     <= slen_next;
        pend_len_reg <= pend_len_next;
        pend_asn_reg <= pend_asn_next;
        status_reg   <= status_next;
        hit_reg      <= hit_next;
        mlen_reg     <= mlen_next;
        asn_reg      <= asn_next;
        last_reg     <= last_next;
        if (wr_en)
        begin
            efam_reg[wr_idx] <= head.item.fam;
            ekey_reg[wr_idx] <= head.item.key;
            elen_reg[wr_idx] <= head.item.plen;
            easn_reg[wr_idx] <= head.item.asn;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign hit       = hit_reg;
    assign match_len = mlen_reg;
    assign asn_out   = asn_reg;
    assign last      = last_reg;

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= apmt_pkg::CNT_W'(apmt_pkg::MAX_OUT))
        else $error("match count beyond cap");

    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (slen_reg != 8'd0))
        else $error("scan ran past length one");

    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> (done_reg && last_reg))
        else $error("lookup ended without final result");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |-> (status_reg == apmt_pkg::ST_OK && mlen_reg != 8'd0))
        else $error("hit result with bad status or length");

endmodule

FILE: sv/all_prefix_match_table.sv
`timescale 1ns / 1ps
// Insert: one table write; the result is registered as the back end pops the entry.
// Lookup: scans one prefix length per cycle, from the longest down to length one or
//   until MAX_OUT matches are found; the last result comes from the final state.
// Throughput is set by the back-end scan; a two-entry queue takes items meanwhile.
// Results are one-cycle strobes on done; the receiver cannot stall.
// Reset clears the queue, the sequencer and all entry valid bits.
module all_prefix_match_table
#(
    parameter int unsigned TABLE_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic        is_ipv6,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic [7:0]  prefix_len,
    input  logic [31:0] asn_in,
    output logic        done,
    output logic [1:0]  status,
    output logic        hit,
    output logic [7:0]  match_len,
    output logic [31:0] asn_out,
    output logic        last
);

    apmt_pkg::head_t head;
    logic            pop;

    // Accept and queue transactions
    apmt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .is_ipv6    (is_ipv6),
        .addr_hi    (addr_hi),
        .addr_lo    (addr_lo),
        .prefix_len (prefix_len),
        .asn_in     (asn_in),
        .pop        (pop),
        .busy       (busy),
        .head       (head)
    );

    // Carry out inserts and lookups
    apmt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .done      (done),
        .status    (status),
        .hit       (hit),
        .match_len (match_len),
        .asn_out   (asn_out),
        .last      (last)
    );

endmodule

FILE: verif/tb_all_prefix_match_table.sv
`timescale 1ns / 1ps
// Testbench for the prefix match routing table: directed and random inserts and lookups.
// Depends on apmt_pkg and all_prefix_match_table; checks every result strobe.
module tb_all_prefix_match_table;

    localparam int DEPTH = 32;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic        op;
        logic        v6;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  plen;
        logic [31:0] asn;
    } route_cmd_t;

    typedef struct {
        logic [1:0]  status;
        logic        hit;
        logic [7:0]  mlen;
        logic [31:0] asn;
        logic        last;
    } route_res_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic        is_ipv6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;
    logic [31:0] asn_in;
    logic        done;
    logic [1:0]  status;
    logic        hit;
    logic [7:0]  match_len;
    logic [31:0] asn_out;
    logic        last;

    route_cmd_t pending_cmds[$];
    route_res_t expected_results[$];

    // shadow routing table
    logic        tbl_valid [DEPTH];
    logic        tbl_v6    [DEPTH];
    logic [63:0] tbl_hi    [DEPTH];
    logic [63:0] tbl_lo    [DEPTH];
    logic [7:0]  tbl_len   [DEPTH];
    logic [31:0] tbl_asn   [DEPTH];

    int     error_count;
    int     result_count;
    int     hit_count;
    int     sent_count;
    int     gap_left;
    longint cycle_count;

    // known subnets that random traffic reuses
    logic [63:0] base_hi [8];
    logic [63:0] base_lo [8];

    all_prefix_match_table #(.TABLE_DEPTH(DEPTH)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .is_ipv6    (is_ipv6),
        .addr_hi    (addr_hi),
        .addr_lo    (addr_lo),
        .prefix_len (prefix_len),
        .asn_in     (asn_in),
        .done       (done),
        .status     (status),
        .hit        (hit),
        .match_len  (match_len),
        .asn_out    (asn_out),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic route_res_t make_res(logic [1:0] st, logic h, logic [7:0] l,
                                            logic [31:0] a, logic lst);
        route_res_t r;
        r.status = st;
        r.hit    = h;
        r.mlen   = l;
        r.asn    = a;
        r.last   = lst;
        return r;
    endfunction

    // Append one expected result
    function automatic void add_expect(input route_res_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Append one pending transaction
    function automatic void queue_cmd(input route_cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Compute expected results of one accepted transaction, update the shadow table
    task automatic predict_route(input route_cmd_t c);
        logic [63:0]  hi;
        logic [63:0]  lo;
        logic [127:0] key;
        logic [127:0] mask;
        int maxlen;
        int slot;
        int n;
        int base;
        hi     = c.v6 ? c.hi : 64'd0;
        lo     = c.v6 ? c.lo : {32'd0, c.lo[31:0]};
        maxlen = c.v6 ? 128 : 32;
        slot   = -1;
        n      = 0;
        base   = expected_results.size();
        if (c.op == apmt_pkg::CMD_INSERT)
        begin
            if (c.plen == 0 || c.plen > maxlen)
            begin
                add_expect(make_res(apmt_pkg::ST_BADLEN, 1'b0, 8'd0, 32'd0, 1'b1));
                return;
            end
            for (int i = 0; i < DEPTH && slot < 0; i++)
                if (tbl_valid[i] && tbl_v6[i] == c.v6 && tbl_len[i] == c.plen &&
                    tbl_hi[i] == hi && tbl_lo[i] == lo)
                    slot = i;
            for (int i = 0; i < DEPTH && slot < 0; i++)
                if (!tbl_valid[i])
                    slot = i;
            if (slot < 0)
            begin
                add_expect(make_res(apmt_pkg::ST_FULL, 1'b0, 8'd0, 32'd0, 1'b1));
                return;
            end
            tbl_valid[slot] = 1'b1;
            tbl_v6[slot]    = c.v6;
            tbl_hi[slot]    = hi;
            tbl_lo[slot]    = lo;
            tbl_len[slot]   = c.plen;
            tbl_asn[slot]   = c.asn;
            add_expect(make_res(apmt_pkg::ST_OK, 1'b0, 8'd0, 32'd0, 1'b1));
        end
        else
        begin
            key = {hi, lo};
            for (int len = maxlen; len >= 1 && n < apmt_pkg::MAX_OUT; len--)
            begin
                if (c.v6)
                    mask = ~128'd0 << (128 - len);
                else
                    mask = {96'd0, 32'hFFFF_FFFF << (32 - len)};
                for (int i = 0; i < DEPTH && n < apmt_pkg::MAX_OUT; i++)
                    if (tbl_valid[i] && tbl_v6[i] == c.v6 && tbl_len[i] == len &&
                        {tbl_hi[i], tbl_lo[i]} == (key & mask))
                    begin
                        add_expect(make_res(apmt_pkg::ST_OK, 1'b1, 8'(len), tbl_asn[i],
                                            1'b0));
                        n++;
                    end
            end
            if (n == 0)
                add_expect(make_res(apmt_pkg::ST_OK, 1'b0, 8'd0, 32'd0, 1'b1));
            else
                expected_results[base + n - 1].last = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %0s: got %0h want %0h (result %0d)", what, got, want,
                 result_count);
        error_count++;
    endtask

    function automatic route_cmd_t mk_cmd(logic op, logic v6, logic [63:0] hi,
                                          logic [63:0] lo, logic [7:0] plen,
                                          logic [31:0] asn);
        route_cmd_t c;
        c.op   = op;
        c.v6   = v6;
        c.hi   = hi;
        c.lo   = lo;
        c.plen = plen;
        c.asn  = asn;
        return c;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random prefix of a random length, mostly under a known subnet; sometimes leaves host bits
    function automatic route_cmd_t rand_route(logic op);
        route_cmd_t   c;
        logic [127:0] k;
        int b;
        int len;
        c.v6 = 1'($urandom_range(0, 1));
        b    = $urandom_range(0, 7);
        k    = {base_hi[b], base_lo[b]};
        if ($urandom_range(0, 3) == 0)
            k = {rand64(), rand64()};
        len = c.v6 ? $urandom_range(1, 128) : $urandom_range(1, 32);
        if (op == apmt_pkg::CMD_INSERT && $urandom_range(0, 9) != 0)
        begin
            if (c.v6)
                k = k & (~128'd0 << (128 - len));
            else
                k = (k & {96'd0, 32'hFFFF_FFFF << (32 - len)}) | {rand64(), 64'd0};
        end
        if (op == apmt_pkg::CMD_INSERT && $urandom_range(0, 15) == 0)
            len = $urandom_range(0, 255);
        c.op   = op;
        c.hi   = k[127:64];
        c.lo   = k[63:0];
        c.plen = 8'(len);
        c.asn  = $urandom();
        return c;
    endfunction

    // Drive transactions, waiting a drawn gap after each before the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            cmd        <= 1'b0;
            is_ipv6    <= 1'b0;
            addr_hi    <= '0;
            addr_lo    <= '0;
            prefix_len <= '0;
            asn_in     <= '0;
            gap_left   <= 0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                predict_route(mk_cmd(cmd, is_ipv6, addr_hi, addr_lo, prefix_len, asn_in));
                sent_count <= sent_count + 1;
            end
            if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                drive_next();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    task automatic drive_next();
        route_cmd_t c;
        c = pending_cmds.pop_front();
        start      <= 1'b1;
        cmd        <= c.op;
        is_ipv6    <= c.v6;
        addr_hi    <= c.hi;
        addr_lo    <= c.lo;
        prefix_len <= c.plen;
        asn_in     <= c.asn;
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 19));
    endtask

    // Check every result strobe against the oldest expectation
    always @(posedge clk)
    begin
        route_res_t w;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (done)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", {status, hit, match_len}, 64'd0);
                end
                else
                begin
                    w = expected_results.pop_front();
                    if (status !== w.status)
                        report_mismatch("status", status, w.status);
                    if (hit !== w.hit)
                        report_mismatch("hit", hit, w.hit);
                    if (match_len !== w.mlen)
                        report_mismatch("match_len", match_len, w.mlen);
                    if (asn_out !== w.asn)
                        report_mismatch("asn_out", asn_out, w.asn);
                    if (last !== w.last)
                        report_mismatch("last", last, w.last);
                    if (w.hit)
                        hit_count++;
                end
            end
        end
    end

    initial
    begin
        route_cmd_t c;
        error_count  = 0;
        result_count = 0;
        hit_count    = 0;
        sent_count   = 0;
        cycle_count  = 0;
        for (int i = 0; i < DEPTH; i++)
            tbl_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            base_hi[i] = rand64();
            base_lo[i] = rand64();
        end
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: bad lengths, extremes, nested matches, overwrite
        queue_cmd(mk_cmd(apmt_pkg::CMD_LOOKUP, 1'b0, '1, '1, 8'd0, 32'd0));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b0, 64'd0, 64'd0, 8'd0, 32'd1));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b0, 64'd0, 64'd0, 8'd33, 32'd2));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b1, 64'd0, 64'd0, 8'd129, 32'd3));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b1, 64'd0, 64'd0, 8'd255, 32'd3));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b0, '1, '1, 8'd32, 32'hFFFF_FFFF));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b0, 64'd0, 64'h8000_0000, 8'd1, 32'd10));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b0, 64'd0, 64'hFFFF_0000, 8'd16, 32'd11));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b0, 64'd0, 64'hFFFF_0000, 8'd16, 32'd12));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b0, 64'd0, 64'h0000_00FF, 8'd8, 32'd13));
        queue_cmd(mk_cmd(apmt_pkg::CMD_LOOKUP, 1'b0, '1, 64'hABCD_FFFF_FFFF, 8'd0, 32'd0));
        queue_cmd(mk_cmd(apmt_pkg::CMD_LOOKUP, 1'b0, 64'd0, 64'hFFFF_FFFF, 8'd7, 32'd0));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b1, '1, '1, 8'd128, 32'd20));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b1, 64'h8000_0000_0000_0000, 64'd0,
                         8'd1, 32'd21));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b1, '1, 64'd0, 8'd64, 32'd22));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b1, '1, 64'h8000_0000_0000_0000,
                         8'd65, 32'd23));
        queue_cmd(mk_cmd(apmt_pkg::CMD_LOOKUP, 1'b1, '1, '1, 8'd0, 32'd0));
        queue_cmd(mk_cmd(apmt_pkg::CMD_LOOKUP, 1'b1, 64'd0, '1, 8'd0, 32'd0));
        // fill the table with nested IPv6 routes so later inserts report full
        for (int l = 100; l <= 127; l++)
            queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b1, '1,
                             ~64'd0 << (128 - l), 8'(l), 32'(100 + l)));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b0, 64'd0, 64'h1234_0000, 8'd16, 32'd99));
        queue_cmd(mk_cmd(apmt_pkg::CMD_INSERT, 1'b0, 64'd0, 64'h1234_0000, 8'd16, 32'd98));
        queue_cmd(mk_cmd(apmt_pkg::CMD_LOOKUP, 1'b1, '1, '1, 8'd0, 32'd0));
        while (pending_cmds.size() > 0 || start)
            @(posedge clk);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        // reset is not repeated: flush the table by overwrite-free churn is impossible,
        // so random traffic continues against the full table
        for (int i = 0; i < 350; i++)
        begin
            c = rand_route($urandom_range(0, 2) == 0 ? apmt_pkg::CMD_INSERT
                                                     : apmt_pkg::CMD_LOOKUP);
            queue_cmd(c);
        end
    end

    // End of run and timeout
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_all_prefix_match_table: done, errors");
            $finish;
        end
        else if (sent_count >= 350 + 48 && pending_cmds.size() == 0 && !start &&
                 expected_results.size() == 0)
        begin
            end_run();
        end
    end

    task automatic end_run();
        repeat (200) @(posedge clk);
        $display("covered %0d transactions, %0d results, %0d hits, %0d errors",
                 sent_count, result_count, hit_count, error_count);
        if (error_count == 0)
            $display("tb_all_prefix_match_table: done, clean");
        else
            $display("tb_all_prefix_match_table: done, errors");
        $finish;
    endtask

endmodule
